/* src/ntm_tape_memory_head_top_macros.svh */
// assertion macros for the ntm tape memory head checker
// expects clk and rst to be visible in the scope that uses them
`ifndef NTM_TAPE_MEMORY_HEAD_TOP_MACROS_SVH
`define NTM_TAPE_MEMORY_HEAD_TOP_MACROS_SVH

// same-cycle implication
`define NTM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntm check failed");

// next-cycle implication
`define NTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntm check failed");

`endif

/* src/ntm_pkg.sv */
// shared constants, types and helper functions for the ntm tape memory head
// no dependencies
`timescale 1ns / 1ps

package ntm_pkg;

  localparam int VEC_LEN    = 8;
  localparam int MEM_DEPTH  = 64;
  localparam int LANE_W     = 8;
  localparam int ENTRY_W    = 64;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int CNT_W      = $clog2(MEM_DEPTH + 1);
  localparam int WEIGHT_W   = 9;
  localparam int SCORE_W    = 16;
  localparam int THR_W      = 16;
  localparam int DIST_W     = $clog2(VEC_LEN * 255 + 1);
  localparam int LIMIT_W    = THR_W + $clog2(VEC_LEN + 1);
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 80;

  localparam logic [WEIGHT_W-1:0] Q_ONE      = 9'd256;
  localparam logic [WEIGHT_W-1:0] GATE_LEVEL = 9'd128;
  localparam logic [THR_W-1:0]    THR_RESET  = 16'd512;
  localparam logic [LANE_W-1:0]   HALF_Q08   = 8'd128;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD_RD,
    ST_HEAD_USE,
    ST_APPEND,
    ST_WRITE_BACK,
    ST_SCAN,
    ST_SCAN_DRAIN,
    ST_DECIDE,
    ST_MOVE,
    ST_OUT
  } ntm_state_t;

  typedef struct packed {
    logic load_item;
    logic read_head;
    logic take_head;
    logic append;
    logic write_back;
    logic scan_start;
    logic scan_read;
    logic decide;
    logic move;
    logic load_out;
  } ntm_cmd_t;

  typedef struct packed {
    logic is_write;
    logic gate_open;
    logic scan_last;
    logic out_free;
  } ntm_status_t;

  function automatic logic [ENTRY_W-1:0] half_entry();
    logic [ENTRY_W-1:0] v;
    v = '0;
    for (int k = 0; k < VEC_LEN; k++) begin
      v[k*LANE_W +: LANE_W] = HALF_Q08;
    end
    return v;
  endfunction

  localparam logic [ENTRY_W-1:0] HALF_ENTRY = half_entry();

endpackage

/* src/ntm_tape_memory_head_top.sv */
// top level of the ntm tape memory head: stream ports, config register port
// depends on ntm_pkg, ntm_ctrl and ntm_datapath
`timescale 1ns / 1ps

// ntm tape memory head
//
// a tape of up to 64 vectors of eight unsigned q0.8 bytes with one head.
// input items arrive on the s_ stream: s_tuser is the mode (0 read, 1 write),
// s_tdata carries the write vector, weight, jump gate and three shift scores.
// each item gives exactly one result item on the m_ stream with the read
// vector, the head position, the used entry count and the jump match flag.
// cfg_we / cfg_wdata write the similarity threshold (q8.8, 2.0 after reset)
// and the user must write it only while no item is in flight: not enforced.
//
// one item is worked at a time; s_tready is high only when the sequencer idles.
// a read takes the head entry and loads the result; a write appends, writes
// the blended entry back, scans and decides on a content jump, then moves the
// head: the jump reads every used entry once through the single tape port.
// the next item can be accepted in the cycle after the result is loaded.
//
// reset clears the head to 0, the used count to 1 and entry 0 to all 0.5.
// the result sits in an output register; a stalled receiver does not block
// the next accept, only the loading of the following result.

module ntm_tape_memory_head_top (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: wr_vector[63:0], write_weight[72:64], jump_gate[81:73],
  //          shift_left[97:82], shift_stay[113:98], shift_right[129:114], zero pad
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ntm_pkg::IN_DATA_W-1:0]      s_tdata,
  // s_tuser: mode[0]
  input  logic                               s_tuser,
  // m_tdata: read_vector[63:0], head_position[69:64], used_entries[76:70],
  //          jump_matched[77], zero pad
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ntm_pkg::OUT_DATA_W-1:0]     m_tdata,
  // similarity_threshold write port
  input  logic                               cfg_we,
  input  logic [ntm_pkg::THR_W-1:0]          cfg_wdata
);
  import ntm_pkg::*;

  ntm_cmd_t    cmd;
  ntm_status_t status;

  // unpacked input fields
  logic [ENTRY_W-1:0]         in_write_vector;
  logic [WEIGHT_W-1:0]        in_write_weight;
  logic [WEIGHT_W-1:0]        in_jump_gate;
  logic signed [SCORE_W-1:0]  in_shift_left;
  logic signed [SCORE_W-1:0]  in_shift_stay;
  logic signed [SCORE_W-1:0]  in_shift_right;

  // registered result fields
  logic [ENTRY_W-1:0]         out_read_vector;
  logic [ADDR_W-1:0]          out_head_position;
  logic [CNT_W-1:0]           out_used_entries;
  logic                       out_jump_matched;

  assign in_write_vector = s_tdata[63:0];
  assign in_write_weight = s_tdata[72:64];
  assign in_jump_gate    = s_tdata[81:73];
  assign in_shift_left   = s_tdata[97:82];
  assign in_shift_stay   = s_tdata[113:98];
  assign in_shift_right  = s_tdata[129:114];

  // result packed low field first, zero filled to whole bytes
  assign m_tdata = OUT_DATA_W'({out_jump_matched, out_used_entries,
                                out_head_position, out_read_vector});

  ntm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ntm_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_mode           (s_tuser),
    .in_write_vector   (in_write_vector),
    .in_write_weight   (in_write_weight),
    .in_jump_gate      (in_jump_gate),
    .in_shift_left     (in_shift_left),
    .in_shift_stay     (in_shift_stay),
    .in_shift_right    (in_shift_right),
    .m_tready          (m_tready),
    .m_tvalid          (m_tvalid),
    .out_read_vector   (out_read_vector),
    .out_head_position (out_head_position),
    .out_used_entries  (out_used_entries),
    .out_jump_matched  (out_jump_matched)
  );

endmodule

/* src/ntm_ctrl.sv */
// sequencer for the ntm tape memory head: one item at a time
// depends on ntm_pkg
`timescale 1ns / 1ps

module ntm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ntm_pkg::ntm_status_t status,
  output ntm_pkg::ntm_cmd_t    cmd
);
  import ntm_pkg::*;

  ntm_state_t state;
  ntm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_HEAD_RD;
        end
      end
      ST_HEAD_RD: begin
        cmd.read_head = 1'b1;
        state_next    = ST_HEAD_USE;
      end
      ST_HEAD_USE: begin
        cmd.take_head = 1'b1;
        state_next    = status.is_write ? ST_APPEND : ST_OUT;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_next = ST_WRITE_BACK;
      end
      ST_WRITE_BACK: begin
        cmd.write_back = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = status.gate_open ? ST_SCAN : ST_MOVE;
      end
      ST_SCAN: begin
        cmd.scan_read = 1'b1;
        if (status.scan_last) begin
          state_next = ST_SCAN_DRAIN;
        end
      end
      ST_SCAN_DRAIN: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_MOVE;
      end
      ST_MOVE: begin
        cmd.move   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/ntm_datapath.sv */
// tape store, head and count registers, blend, distance scan and output register
// depends on ntm_pkg; driven by ntm_ctrl commands
`timescale 1ns / 1ps

module ntm_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  ntm_pkg::ntm_cmd_t                cmd,
  output ntm_pkg::ntm_status_t             status,
  input  logic                             cfg_we,
  input  logic [ntm_pkg::THR_W-1:0]        cfg_wdata,
  input  logic                             in_mode,
  input  logic [ntm_pkg::ENTRY_W-1:0]      in_write_vector,
  input  logic [ntm_pkg::WEIGHT_W-1:0]     in_write_weight,
  input  logic [ntm_pkg::WEIGHT_W-1:0]     in_jump_gate,
  input  logic signed [ntm_pkg::SCORE_W-1:0] in_shift_left,
  input  logic signed [ntm_pkg::SCORE_W-1:0] in_shift_stay,
  input  logic signed [ntm_pkg::SCORE_W-1:0] in_shift_right,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [ntm_pkg::ENTRY_W-1:0]      out_read_vector,
  output logic [ntm_pkg::ADDR_W-1:0]       out_head_position,
  output logic [ntm_pkg::CNT_W-1:0]        out_used_entries,
  output logic                             out_jump_matched
);
  import ntm_pkg::*;

  function automatic logic [ENTRY_W-1:0] blend_entry(input logic [ENTRY_W-1:0] old_e,
                                                     input logic [ENTRY_W-1:0] new_e,
                                                     input logic [WEIGHT_W-1:0] w);
    logic signed [LANE_W+1:0]   d;
    logic signed [2*LANE_W+3:0] p;
    logic signed [2*LANE_W+3:0] q;
    logic [LANE_W+1:0]          s;
    logic [ENTRY_W-1:0]         r;
    r = '0;
    // old*(256-w)+new*w >> 8 is old + floor((new-old)*w / 256)
    for (int k = 0; k < VEC_LEN; k++) begin
      d = $signed({2'b00, new_e[k*LANE_W +: LANE_W]})
        - $signed({2'b00, old_e[k*LANE_W +: LANE_W]});
      p = (2*LANE_W+4)'(d) * (2*LANE_W+4)'($signed({1'b0, w}));
      q = p >>> LANE_W;
      s = {2'b00, old_e[k*LANE_W +: LANE_W]} + q[LANE_W+1:0];
      r[k*LANE_W +: LANE_W] = s[LANE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [DIST_W-1:0] l1_dist(input logic [ENTRY_W-1:0] a,
                                                input logic [ENTRY_W-1:0] b);
    logic [LANE_W-1:0] x;
    logic [LANE_W-1:0] y;
    logic [DIST_W-1:0] s;
    s = '0;
    for (int k = 0; k < VEC_LEN; k++) begin
      x = a[k*LANE_W +: LANE_W];
      y = b[k*LANE_W +: LANE_W];
      s = s + DIST_W'((x > y) ? (x - y) : (y - x));
    end
    return s;
  endfunction

  // tape store, single port with registered read
  logic [ENTRY_W-1:0] tape [MEM_DEPTH];
  logic [ENTRY_W-1:0] rdata_raw;
  logic               rd_fresh;
  logic               e0_written;
  logic [ENTRY_W-1:0] rdata;

  logic [THR_W-1:0]    thr;
  logic [ADDR_W-1:0]   head;
  logic [ADDR_W-1:0]   head_next;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   last_idx;

  logic                mode_r;
  logic [ENTRY_W-1:0]  wv_r;
  logic [WEIGHT_W-1:0] w_r;
  logic                gate_open_r;
  logic signed [SCORE_W-1:0] sl_r;
  logic signed [SCORE_W-1:0] sn_r;
  logic signed [SCORE_W-1:0] sr_r;

  logic [ENTRY_W-1:0]  blend_r;
  logic [ENTRY_W-1:0]  rv_r;
  logic                matched_r;

  logic [ADDR_W-1:0]   scan_idx;
  logic                eval_pending;
  logic [ADDR_W-1:0]   eval_idx;
  logic [DIST_W-1:0]   best_d;
  logic [ADDR_W-1:0]   best_idx;
  logic [DIST_W-1:0]   cur_dist;
  logic [LIMIT_W-1:0]  limit;

  logic                append_en;
  logic                mem_we;
  logic                mem_re;
  logic [ADDR_W-1:0]   mem_addr;
  logic [ENTRY_W-1:0]  mem_wdata;

  assign last_idx  = ADDR_W'(count - CNT_W'(1));
  assign append_en = cmd.append && (head == last_idx) && (count < CNT_W'(MEM_DEPTH));
  assign mem_we    = append_en || cmd.write_back;
  assign mem_re    = cmd.read_head || cmd.scan_read;
  assign mem_wdata = append_en ? HALF_ENTRY : blend_r;

  always_comb begin
    priority if (cmd.append) begin
      mem_addr = count[ADDR_W-1:0];
    end else if (cmd.scan_read) begin
      mem_addr = scan_idx;
    end else begin
      mem_addr = head;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_raw <= tape[mem_addr];
    end
  end

  // entry 0 reads as all 0.5 until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      e0_written <= 1'b0;
      rd_fresh   <= 1'b0;
    end else begin
      if (mem_we && mem_addr == '0) begin
        e0_written <= 1'b1;
      end
      if (mem_re) begin
        rd_fresh <= (mem_addr == '0) && !e0_written;
      end
    end
  end

  assign rdata = rd_fresh ? HALF_ENTRY : rdata_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r      <= in_mode;
      wv_r        <= in_write_vector;
      w_r         <= (in_write_weight > Q_ONE) ? Q_ONE : in_write_weight;
      gate_open_r <= in_jump_gate > GATE_LEVEL;
      sl_r        <= in_shift_left;
      sn_r        <= in_shift_stay;
      sr_r        <= in_shift_right;
    end
    if (cmd.take_head && mode_r) begin
      blend_r <= blend_entry(rdata, wv_r, w_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      rv_r <= '0;
    end else if (cmd.take_head && !mode_r) begin
      rv_r <= rdata;
    end
  end

  // content scan: distance evaluated in the cycle after its read is issued
  assign cur_dist = l1_dist(wv_r, rdata);
  assign limit    = LIMIT_W'(thr) * LIMIT_W'(VEC_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_pending <= 1'b0;
    end else begin
      eval_pending <= cmd.scan_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_read) begin
      scan_idx <= scan_idx + ADDR_W'(1);
    end
    if (cmd.scan_read) begin
      eval_idx <= scan_idx;
    end
    if (eval_pending && (eval_idx == '0 || cur_dist < best_d)) begin
      best_d   <= cur_dist;
      best_idx <= eval_idx;
    end
  end

  // head shift with wrap-around over used entries
  always_comb begin
    if (sl_r >= sn_r && sl_r >= sr_r) begin
      head_next = (head == '0) ? last_idx : head - ADDR_W'(1);
    end else if (sr_r > sn_r) begin
      head_next = ({1'b0, head} + CNT_W'(1) >= count) ? '0 : head + ADDR_W'(1);
    end else begin
      head_next = head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= CNT_W'(1);
      matched_r <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        matched_r <= 1'b0;
      end
      if (append_en) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.decide) begin
        if (LIMIT_W'(best_d) < limit) begin
          head      <= best_idx;
          matched_r <= 1'b1;
        end else begin
          head <= last_idx;
        end
      end else if (cmd.move) begin
        head <= head_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_vector   <= rv_r;
      out_head_position <= head;
      out_used_entries  <= count;
      out_jump_matched  <= matched_r;
    end
  end

  assign status.is_write  = mode_r;
  assign status.gate_open = gate_open_r;
  assign status.scan_last = (scan_idx == last_idx);
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

/* src/ntm_checker.sv */
// port-level checks for the ntm tape memory head, bound to the top level
// depends on ntm_pkg and ntm_tape_memory_head_top_macros.svh
`timescale 1ns / 1ps

`include "ntm_tape_memory_head_top_macros.svh"

module ntm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ntm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ntm_pkg::*;

  // a stalled result holds
  `NTM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // one item in flight: no accept right after an accept
  `NTM_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

  // head stays inside the used entries, at least one entry in use
  `NTM_ASSERT_NOW(a_head_in_range, m_tvalid,
                  (m_tdata[76:70] != 7'd0) && ({1'b0, m_tdata[69:64]} < m_tdata[76:70]))

  // a jump match only comes from a write, whose read vector is zero
  `NTM_ASSERT_NOW(a_match_is_write, m_tvalid && m_tdata[77], m_tdata[63:0] == 64'd0)

endmodule

bind ntm_tape_memory_head_top ntm_checker u_ntm_checker (.*);
